### hw/rtl/utt_pkg.sv
// utt_pkg: types, constants and decode helpers of the utf-8 to utf-16 transcoder
// used by the decoder, the burst buffer and the top level; no dependencies
package utt_pkg;

  localparam int MaxResults = 5;
  localparam int ResIdxW    = 3;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [20:0] SUPP_BASE      = 21'h010000;
  localparam logic [15:0] SURR_HI        = 16'hD800;
  localparam logic [15:0] SURR_LO        = 16'hDC00;
  localparam logic [16:0] NEEDED_SAT     = 17'h10000;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        last_of_run;
    logic [15:0] units_written;
    logic [16:0] units_needed;
  } result_t;

  typedef struct packed {
    logic [ResIdxW-1:0]           count;
    result_t [MaxResults-1:0]     res;
  } burst_t;

  typedef struct packed {
    logic [1:0]  n;
    logic [15:0] u0;
    logic [15:0] u1;
    logic [15:0] wr;
    logic [16:0] nd;
  } emit_t;

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic logic [20:0] utf8_decode(input logic [7:0] s0, input logic [7:0] s1,
                                              input logic [7:0] s2, input logic [7:0] s3,
                                              input logic [2:0] len);
    logic [20:0] cp;
    if (len == 3'd2) begin
      cp = {10'd0, s0[4:0], s1[5:0]};
    end else if (len == 3'd3) begin
      cp = {5'd0, s0[3:0], s1[5:0], s2[5:0]};
    end else begin
      cp = {s0[2:0], s1[5:0], s2[5:0], s3[5:0]};
    end
    return cp;
  endfunction

  // count one code point and write its units if they fit
  function automatic emit_t emit_cp(input logic [20:0] cp, input logic ok,
                                    input logic [15:0] wr, input logic [16:0] nd,
                                    input logic [15:0] cap);
    emit_t       e;
    logic        big;
    logic [17:0] sum;
    logic [20:0] v;
    e.n  = 2'd0;
    e.u0 = 16'h0000;
    e.u1 = 16'h0000;
    e.wr = wr;
    e.nd = nd;
    big  = (cp >= SUPP_BASE);
    v    = cp - SUPP_BASE;
    sum  = {1'b0, nd} + (big ? 18'd2 : 18'd1);
    if (ok) begin
      e.nd = (sum > {1'b0, NEEDED_SAT}) ? NEEDED_SAT : sum[16:0];
      if (!big) begin
        if (wr < cap) begin
          e.n  = 2'd1;
          e.u0 = cp[15:0];
          e.wr = wr + 16'd1;
        end
      end else if (({1'b0, wr} + 17'd1) < {1'b0, cap}) begin
        e.n  = 2'd2;
        e.u0 = SURR_HI | {5'd0, v[20:10]};
        e.u1 = SURR_LO | {6'd0, v[9:0]};
        e.wr = wr + 16'd2;
      end
    end
    return e;
  endfunction

  function automatic result_t unit_result(input logic [15:0] u);
    result_t r;
    r.code_unit     = u;
    r.unit_valid    = 1'b1;
    r.last_of_run   = 1'b0;
    r.units_written = 16'h0000;
    r.units_needed  = 17'h00000;
    return r;
  endfunction

endpackage

### hw/rtl/utt_byte_if.sv
// utt_byte_if: input channel of the transcoder, one utf-8 byte per word
// no dependencies
interface utt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

### hw/rtl/utt_unit_if.sv
// utt_unit_if: output channel of the transcoder, one utf-16 unit or summary per word
// no dependencies
interface utt_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        last_of_run;
  logic [15:0] units_written;
  logic [16:0] units_needed;

  modport source (output valid, output code_unit, output unit_valid, output last_of_run,
                  output units_written, output units_needed, input ready);
  modport sink   (input valid, input code_unit, input unit_valid, input last_of_run,
                  input units_written, input units_needed, output ready);
endinterface

### hw/rtl/utt_decoder.sv
// utt_decoder: input register, sequence state, capacity register and the
// single-pass decode that builds the burst of results for one byte
// depends on utt_pkg and utt_byte_if
module utt_decoder
  import utt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  utt_byte_if.sink    byte_i,
  input  logic        free_i,
  output logic        load_o,
  output burst_t      burst_o
);

  logic        in_v_q;
  logic [7:0]  in_byte_q;
  logic        in_eos_q;
  logic [15:0] cap_q;
  logic [7:0]  pend_q [3];
  logic [7:0]  pend_d [3];
  logic [1:0]  pcnt_q, pcnt_d;
  logic [2:0]  elen_q, elen_d;
  logic [15:0] wr_q, wr_d;
  logic [16:0] nd_q, nd_d;

  logic        proc;
  logic [2:0]  len_b;
  logic        main_v;
  logic [20:0] main_cp;
  logic [7:0]  s1, s2;
  logic        flush;
  logic        f1_v, f2_v;
  logic [20:0] f1_cp, f2_cp;
  logic [20:0] c0_cp;
  logic        c0_v;
  emit_t       e0, e1, e2;
  logic [ResIdxW-1:0] cnt;
  result_t [MaxResults-1:0] res;
  result_t     summ;

  assign proc         = in_v_q && free_i;
  assign load_o       = proc;
  assign byte_i.ready = !in_v_q || proc;

  always_comb begin
    pend_d  = pend_q;
    pcnt_d  = pcnt_q;
    elen_d  = elen_q;
    main_v  = 1'b0;
    main_cp = 21'd0;
    len_b   = seq_len(in_byte_q);
    s1      = (pcnt_q >= 2'd2) ? pend_q[1] : in_byte_q;
    s2      = (pcnt_q == 2'd3) ? pend_q[2] : in_byte_q;
    if (pcnt_q == 2'd0) begin
      if (len_b == 3'd1) begin
        main_v  = 1'b1;
        main_cp = {13'd0, in_byte_q};
      end else if (len_b == 3'd0) begin
        main_v  = 1'b1;
        main_cp = REPLACEMENT_CP;
      end else begin
        pend_d[0] = in_byte_q;
        pcnt_d    = 2'd1;
        elen_d    = len_b;
      end
    end else if (({1'b0, pcnt_q} + 3'd1) >= elen_q) begin
      main_v  = 1'b1;
      main_cp = utf8_decode(pend_q[0], s1, s2, in_byte_q, elen_q);
      pcnt_d  = 2'd0;
      elen_d  = 3'd0;
    end else begin
      pend_d[pcnt_q] = in_byte_q;
      pcnt_d         = pcnt_q + 2'd1;
    end

    // string cut inside a sequence: lead gives replacement, the rest decoded again
    flush = in_eos_q && (pcnt_d != 2'd0);
    f1_v  = flush && (pcnt_d >= 2'd2);
    f2_v  = 1'b0;
    f1_cp = REPLACEMENT_CP;
    f2_cp = REPLACEMENT_CP;
    if (seq_len(pend_d[1]) == 3'd1) begin
      f1_cp = {13'd0, pend_d[1]};
    end else if ((pcnt_d == 2'd3) && (seq_len(pend_d[1]) == 3'd2)) begin
      f1_cp = utf8_decode(pend_d[1], pend_d[2], 8'd0, 8'd0, 3'd2);
    end
    if (flush && (pcnt_d == 2'd3) && (seq_len(pend_d[1]) != 3'd2)) begin
      f2_v = 1'b1;
    end
    if (seq_len(pend_d[2]) == 3'd1) begin
      f2_cp = {13'd0, pend_d[2]};
    end
    if (in_eos_q) begin
      pcnt_d = 2'd0;
      elen_d = 3'd0;
    end

    c0_v  = main_v || flush;
    c0_cp = main_v ? main_cp : REPLACEMENT_CP;
    e0    = emit_cp(c0_cp, c0_v, wr_q, nd_q, cap_q);
    e1    = emit_cp(f1_cp, f1_v, e0.wr, e0.nd, cap_q);
    e2    = emit_cp(f2_cp, f2_v, e1.wr, e1.nd, cap_q);

    res = '0;
    cnt = '0;
    if (e0.n != 2'd0) begin
      res[cnt] = unit_result(e0.u0);
      cnt      = cnt + 1'b1;
    end
    if (e0.n == 2'd2) begin
      res[cnt] = unit_result(e0.u1);
      cnt      = cnt + 1'b1;
    end
    if (e1.n != 2'd0) begin
      res[cnt] = unit_result(e1.u0);
      cnt      = cnt + 1'b1;
    end
    if (e2.n != 2'd0) begin
      res[cnt] = unit_result(e2.u0);
      cnt      = cnt + 1'b1;
    end
    summ.code_unit     = 16'h0000;
    summ.unit_valid    = 1'b0;
    summ.last_of_run   = 1'b0;
    summ.units_written = e2.wr;
    summ.units_needed  = e2.nd;
    if (in_eos_q) begin
      res[cnt] = summ;
      cnt      = cnt + 1'b1;
    end
    if (cnt != '0) begin
      res[cnt - 1'b1].last_of_run = 1'b1;
    end
    burst_o.count = cnt;
    burst_o.res   = res;

    wr_d = in_eos_q ? 16'h0000 : e2.wr;
    nd_d = in_eos_q ? 17'h00000 : e2.nd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      cap_q  <= 16'h0000;
      pcnt_q <= 2'd0;
      elen_q <= 3'd0;
      wr_q   <= 16'h0000;
      nd_q   <= 17'h00000;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (byte_i.valid && byte_i.ready) begin
        in_v_q <= 1'b1;
      end else if (proc) begin
        in_v_q <= 1'b0;
      end
      if (proc) begin
        pcnt_q <= pcnt_d;
        elen_q <= elen_d;
        wr_q   <= wr_d;
        nd_q   <= nd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
      in_eos_q  <= byte_i.end_of_string;
    end
    if (proc) begin
      pend_q <= pend_d;
    end
  end

  a_pend_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pcnt_q != 2'd0) |-> ({1'b0, pcnt_q} < elen_q))
    else $error("pending count not below sequence length");

  a_idle_len_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pcnt_q == 2'd0) |-> (elen_q == 3'd0))
    else $error("sequence length left set with nothing pending");

  a_needed_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nd_q <= NEEDED_SAT)
    else $error("needed count beyond saturation");

endmodule

### hw/rtl/utt_burst.sv
// utt_burst: holds the results of one byte and feeds them one word a cycle
// into the output register while unit_o is ready; needs utt_pkg, utt_unit_if
module utt_burst
  import utt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  burst_t      burst_i,
  output logic        free_o,
  utt_unit_if.source  unit_o
);

  result_t [MaxResults-1:0] res_q;
  logic [ResIdxW-1:0] bcnt_q, bcnt_d;
  logic [ResIdxW-1:0] bidx_q, bidx_d;
  logic    out_v_q, out_v_d;
  result_t out_q;
  logic    out_load;
  logic    last_entry;

  assign last_entry = (bidx_q == (bcnt_q - 1'b1));
  assign out_load   = (bcnt_q != '0) && (!out_v_q || unit_o.ready);
  assign free_o     = (bcnt_q == '0) || (out_load && last_entry);

  always_comb begin
    bcnt_d  = bcnt_q;
    bidx_d  = bidx_q;
    out_v_d = out_v_q;
    if (out_load) begin
      out_v_d = 1'b1;
      if (last_entry) begin
        bcnt_d = '0;
        bidx_d = '0;
      end else begin
        bidx_d = bidx_q + 1'b1;
      end
    end else if (unit_o.ready) begin
      out_v_d = 1'b0;
    end
    if (load_i) begin
      bcnt_d = burst_i.count;
      bidx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q  <= '0;
      bidx_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      bcnt_q  <= bcnt_d;
      bidx_q  <= bidx_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= burst_i.res;
    end
    if (out_load) begin
      out_q <= res_q[bidx_q];
    end
  end

  assign unit_o.valid         = out_v_q;
  assign unit_o.code_unit     = out_q.code_unit;
  assign unit_o.unit_valid    = out_q.unit_valid;
  assign unit_o.last_of_run   = out_q.last_of_run;
  assign unit_o.units_written = out_q.units_written;
  assign unit_o.units_needed  = out_q.units_needed;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bcnt_q != '0) |-> (bidx_q < bcnt_q))
    else $error("burst read index past burst count");

  a_burst_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bcnt_q != '0) |-> res_q[bcnt_q - 1'b1].last_of_run)
    else $error("burst does not end in a last-of-run word");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.unit_valid) |-> out_q.last_of_run)
    else $error("summary word not marked last of run");

endmodule

### hw/rtl/utf8_to_utf16_transcoder.sv
// utf8_to_utf16_transcoder: top level, lenient utf-8 to utf-16 conversion
// depends on utt_pkg, utt_byte_if, utt_unit_if, utt_decoder and utt_burst
//
// byte_i takes one utf-8 byte per word, end_of_string marks the last byte.
// unit_o gives utf-16 units (unit_valid high) and, after the last byte of a
// string, a summary word (unit_valid low) with units written and needed.
// last_of_run flags the final word caused by one input byte; a byte that
// only extends a pending sequence causes no word.
// cfg_we_i/cfg_wdata_i write output_capacity; 0 counts without writing units.
// a byte accepted into the input register is decoded into the burst buffer,
// and its first word then reaches unit_o through the output register.
// throughput is one byte a cycle while each byte gives at most one word and
// unit_o is ready; a byte giving more words holds byte_i while the burst
// buffer drains through the single output register.
// when unit_o stalls, the waiting word stays in the output register, the
// burst buffer holds the remaining words of at most one byte and one more
// byte is taken into the input register before ready drops.
// reset clears pending bytes state, counts and capacity (to count only).
module utf8_to_utf16_transcoder
  import utt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  utt_byte_if.sink    byte_i,
  utt_unit_if.source  unit_o
);

  logic   free;
  logic   load;
  burst_t burst;

  utt_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (byte_i),
    .free_i      (free),
    .load_o      (load),
    .burst_o     (burst)
  );

  utt_burst u_burst (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .burst_i (burst),
    .free_o  (free),
    .unit_o  (unit_o)
  );

endmodule
